// ===== rtl/sfb_pkg.sv =====
// Shared constants, types and codes of the seam feather blend.
`default_nettype none

package sfb_pkg;

    // Largest image width that the blend width logic honors.
    localparam int MAX_COLUMNS = 4096;

    // Blend width limits.
    localparam int MIN_LEFT_WIDTH = 100;
    localparam int WIDE_CAP       = 350;
    localparam int NARROW_CAP     = 50;

    // Field widths.
    localparam int COL_W  = 12;
    localparam int SEAM_W = 12;
    localparam int WID_W  = 13;
    localparam int PIX_W  = 8;
    localparam int NCH    = 3;

    // Blend width register width: enough for half of the largest image and for the caps.
    localparam int BW_W = (($clog2(MAX_COLUMNS) - 1) > 9) ? ($clog2(MAX_COLUMNS) - 1) : 9;
    // Numerator s*(W-j)+d*j stays below 256*W.
    localparam int NUM_W = BW_W + PIX_W;
    // Reciprocal scale 2^RCP_SH and reciprocal width.
    localparam int RCP_SH = NUM_W;
    localparam int RCP_W  = RCP_SH + 1;
    localparam int CNT_W  = $clog2(RCP_W);
    localparam int CMP_W  = (COL_W > BW_W) ? COL_W : BW_W;

    // Queue between front and back.
    localparam int FIFO_DEPTH = 4;

    // Configuration register indexes.
    localparam logic [1:0] REG_SEAM  = 2'd0;
    localparam logic [1:0] REG_WIDTH = 2'd1;
    localparam logic [1:0] REG_WIDE  = 2'd2;

    typedef enum logic [1:0] {
        CFG_CALC,
        CFG_DIV,
        CFG_READY
    } cfg_state_t;

    // Derived blend settings handed from the configuration unit.
    typedef struct packed {
        logic             ready;
        logic [BW_W-1:0]  bw;
        logic [RCP_W-1:0] recip;
    } cfg_stat_t;

    // Classified word that travels through the queue.
    typedef struct packed {
        logic                       blend;
        logic                       in_span;
        logic [BW_W-1:0]            col;
        logic [NCH-1:0][PIX_W-1:0]  src;
        logic [NCH-1:0][PIX_W-1:0]  dst;
    } item_t;

endpackage

`default_nettype wire

// ===== rtl/sfb_cfg.sv =====
// Configuration registers, blend width derivation and reciprocal sequencer.
`default_nettype none

module sfb_cfg (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_valid,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [sfb_pkg::WID_W-1:0] cfg_data,
    output sfb_pkg::cfg_stat_t             stat
);

    logic [sfb_pkg::SEAM_W-1:0] seam_reg, seam_next;
    logic [sfb_pkg::WID_W-1:0]  width_reg, width_next;
    logic                       wide_reg, wide_next;
    sfb_pkg::cfg_state_t        state_reg, state_next;
    logic [sfb_pkg::BW_W-1:0]   bw_reg, bw_next;
    logic [sfb_pkg::BW_W-1:0]   rem_reg, rem_next;
    logic [sfb_pkg::RCP_W-1:0]  recip_reg, recip_next;
    logic [sfb_pkg::CNT_W-1:0]  cnt_reg, cnt_next;

    logic [sfb_pkg::WID_W-1:0]  wsat;
    logic [sfb_pkg::WID_W-1:0]  half;
    logic [sfb_pkg::WID_W-1:0]  diff;
    logic [sfb_pkg::WID_W-1:0]  cap;
    logic [sfb_pkg::BW_W-1:0]   bw_calc;
    logic [sfb_pkg::BW_W:0]     trial;

    // Blend width from the current registers.
    always_comb
    begin
        if (int'(width_reg) > sfb_pkg::MAX_COLUMNS)
        begin
            wsat = sfb_pkg::WID_W'(sfb_pkg::MAX_COLUMNS);
        end
        else
        begin
            wsat = width_reg;
        end
        half = wsat >> 1;
        diff = wsat - sfb_pkg::WID_W'(seam_reg);
        cap  = wide_reg ? sfb_pkg::WID_W'(sfb_pkg::WIDE_CAP) : sfb_pkg::WID_W'(sfb_pkg::NARROW_CAP);
        if (sfb_pkg::WID_W'(seam_reg) < half)
        begin
            if (seam_reg < sfb_pkg::SEAM_W'(sfb_pkg::MIN_LEFT_WIDTH))
            begin
                bw_calc = sfb_pkg::BW_W'(sfb_pkg::MIN_LEFT_WIDTH);
            end
            else
            begin
                bw_calc = sfb_pkg::BW_W'(seam_reg);
            end
        end
        else if (sfb_pkg::WID_W'(seam_reg) >= wsat)
        begin
            bw_calc = '0;
        end
        else if (diff > cap)
        begin
            bw_calc = sfb_pkg::BW_W'(cap);
        end
        else
        begin
            bw_calc = sfb_pkg::BW_W'(diff);
        end
    end

    // One quotient bit of 2^RCP_SH / bw per cycle.
    assign trial = {rem_reg, (cnt_reg == sfb_pkg::CNT_W'(sfb_pkg::RCP_SH))};

    always_comb
    begin
        seam_next  = seam_reg;
        width_next = width_reg;
        wide_next  = wide_reg;
        state_next = state_reg;
        bw_next    = bw_reg;
        rem_next   = rem_reg;
        recip_next = recip_reg;
        cnt_next   = cnt_reg;

        case (state_reg)
            sfb_pkg::CFG_CALC:
            begin
                bw_next    = bw_calc;
                rem_next   = '0;
                recip_next = '0;
                cnt_next   = sfb_pkg::CNT_W'(sfb_pkg::RCP_SH);
                state_next = (bw_calc == '0) ? sfb_pkg::CFG_READY : sfb_pkg::CFG_DIV;
            end
            sfb_pkg::CFG_DIV:
            begin
                if (trial >= {1'b0, bw_reg})
                begin
                    rem_next   = sfb_pkg::BW_W'(trial - {1'b0, bw_reg});
                    recip_next = {recip_reg[sfb_pkg::RCP_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next   = sfb_pkg::BW_W'(trial);
                    recip_next = {recip_reg[sfb_pkg::RCP_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = sfb_pkg::CFG_READY;
                end
            end
            sfb_pkg::CFG_READY:
            begin
                state_next = sfb_pkg::CFG_READY;
            end
            default:
            begin
                state_next = sfb_pkg::CFG_CALC;
            end
        endcase

        // A register write restarts the derivation.
        if (cfg_valid)
        begin
            case (cfg_index)
                sfb_pkg::REG_SEAM:
                begin
                    seam_next  = cfg_data[sfb_pkg::SEAM_W-1:0];
                    state_next = sfb_pkg::CFG_CALC;
                end
                sfb_pkg::REG_WIDTH:
                begin
                    width_next = cfg_data;
                    state_next = sfb_pkg::CFG_CALC;
                end
                sfb_pkg::REG_WIDE:
                begin
                    wide_next  = cfg_data[0];
                    state_next = sfb_pkg::CFG_CALC;
                end
                default:
                begin
                    state_next = state_next;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seam_reg  <= '0;
            width_reg <= sfb_pkg::WID_W'(4096);
            wide_reg  <= 1'b0;
            state_reg <= sfb_pkg::CFG_CALC;
        end
        else
        begin
            seam_reg  <= seam_next;
            width_reg <= width_next;
            wide_reg  <= wide_next;
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bw_reg    <= bw_next;
        rem_reg   <= rem_next;
        recip_reg <= recip_next;
        cnt_reg   <= cnt_next;
    end

    assign stat.ready = (state_reg == sfb_pkg::CFG_READY);
    assign stat.bw    = bw_reg;
    assign stat.recip = recip_reg;

    // The finished reciprocal is floor(2^RCP_SH / bw).
    a_recip_exact: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sfb_pkg::CFG_READY && bw_reg != '0) |->
        (64'(recip_reg) * 64'(bw_reg) <= (64'd1 << sfb_pkg::RCP_SH)) &&
        ((64'(recip_reg) + 64'd1) * 64'(bw_reg) > (64'd1 << sfb_pkg::RCP_SH)))
        else $error("reciprocal of blend width is wrong");

endmodule

`default_nettype wire

// ===== rtl/sfb_front.sv =====
// Front part: takes pixel pairs, classifies them and hands words to the queue.
`default_nettype none

module sfb_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [sfb_pkg::COL_W-1:0] column,
    input  wire logic [sfb_pkg::PIX_W-1:0] src_red,
    input  wire logic [sfb_pkg::PIX_W-1:0] src_green,
    input  wire logic [sfb_pkg::PIX_W-1:0] src_blue,
    input  wire logic [sfb_pkg::PIX_W-1:0] dst_red,
    input  wire logic [sfb_pkg::PIX_W-1:0] dst_green,
    input  wire logic [sfb_pkg::PIX_W-1:0] dst_blue,
    input  sfb_pkg::cfg_stat_t             stat,
    output logic                           push,
    output sfb_pkg::item_t                 push_data,
    input  wire logic                      q_full
);

    logic           valid_reg, valid_next;
    sfb_pkg::item_t item_reg, item_next;
    logic           accept;
    logic           col_in_span;

    assign col_in_span = sfb_pkg::CMP_W'(column) < sfb_pkg::CMP_W'(stat.bw);
    assign in_stall = !stat.ready || (valid_reg && q_full);
    assign accept   = in_valid && !in_stall;
    assign push     = valid_reg && !q_full;
    assign push_data = item_reg;

    always_comb
    begin
        item_next         = item_reg;
        item_next.in_span = col_in_span;
        item_next.blend   = col_in_span && ((src_red | src_green | src_blue) != '0);
        item_next.col     = sfb_pkg::BW_W'(column);
        item_next.src     = {src_blue, src_green, src_red};
        item_next.dst     = {dst_blue, dst_green, dst_red};
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    // No word is taken while the blend settings are still being derived.
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !stat.ready |-> in_stall)
        else $error("word accepted while configuration busy");

endmodule

`default_nettype wire

// ===== rtl/sfb_fifo.sv =====
// Short queue of classified words between front and back.
`default_nettype none

module sfb_fifo (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  sfb_pkg::item_t push_data,
    output logic          full,
    input  wire logic     pop,
    output sfb_pkg::item_t pop_data,
    output logic          empty
);

    localparam int PTR_W = $clog2(sfb_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(sfb_pkg::FIFO_DEPTH + 1);

    sfb_pkg::item_t     mem [sfb_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_reg, wr_next;
    logic [PTR_W-1:0]   rd_reg, rd_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign full     = (count_reg == CNT_W'(sfb_pkg::FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_reg];

    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == PTR_W'(sfb_pkg::FIFO_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PTR_W'(sfb_pkg::FIFO_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(sfb_pkg::FIFO_DEPTH))
        else $error("queue fill count out of range");

endmodule

`default_nettype wire

// ===== rtl/sfb_back.sv =====
// Back part: feather blend pipeline with exact division by the blend width.
`default_nettype none

module sfb_back (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  sfb_pkg::cfg_stat_t             stat,
    input  wire logic                      q_empty,
    output logic                           pop,
    input  sfb_pkg::item_t                 pop_data,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [sfb_pkg::PIX_W-1:0]      out_red,
    output logic [sfb_pkg::PIX_W-1:0]      out_green,
    output logic [sfb_pkg::PIX_W-1:0]      out_blue,
    output logic                           in_blend
);

    localparam int NUM_W  = sfb_pkg::NUM_W;
    localparam int PIX_W  = sfb_pkg::PIX_W;
    localparam int NCH    = sfb_pkg::NCH;
    localparam int PROD_W = sfb_pkg::NUM_W + sfb_pkg::RCP_W;

    logic advance;

    // Stage 1: numerator.
    logic                           s1_valid_reg;
    logic                           s1_blend_reg, s1_inside_reg;
    logic [NCH-1:0][PIX_W-1:0]      s1_dst_reg;
    logic [NCH-1:0][NUM_W-1:0]      s1_num_reg, s1_num_next;
    // Stage 2: quotient estimate.
    logic                           s2_valid_reg;
    logic                           s2_blend_reg, s2_inside_reg;
    logic [NCH-1:0][PIX_W-1:0]      s2_dst_reg;
    logic [NCH-1:0][NUM_W-1:0]      s2_num_reg;
    logic [NCH-1:0][PIX_W-1:0]      s2_q_reg, s2_q_next;
    // Stage 3: estimate times width.
    logic                           s3_valid_reg;
    logic                           s3_blend_reg, s3_inside_reg;
    logic [NCH-1:0][PIX_W-1:0]      s3_dst_reg;
    logic [NCH-1:0][NUM_W-1:0]      s3_num_reg;
    logic [NCH-1:0][PIX_W-1:0]      s3_q_reg;
    logic [NCH-1:0][NUM_W-1:0]      s3_qw_reg, s3_qw_next;
    // Output register.
    logic                           out_valid_reg, out_valid_next;
    logic [NCH-1:0][PIX_W-1:0]      out_pix_reg, out_pix_next;
    logic                           out_inside_reg;

    logic [sfb_pkg::BW_W-1:0]       rest;
    logic [NCH-1:0][PROD_W-1:0]     s2_prod;
    logic [NCH-1:0][NUM_W-1:0]      s4_rem;

    // The whole pipeline moves whenever the output register is free or being taken.
    assign advance = !out_valid_reg || !out_stall;
    assign pop     = advance && !q_empty;
    assign rest    = stat.bw - pop_data.col;

    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            s1_num_next[c] = NUM_W'(pop_data.src[c]) * NUM_W'(rest)
                           + NUM_W'(pop_data.dst[c]) * NUM_W'(pop_data.col);
            s2_prod[c]     = PROD_W'(s1_num_reg[c]) * PROD_W'(stat.recip);
            s2_q_next[c]   = s2_prod[c][sfb_pkg::RCP_SH + PIX_W - 1:sfb_pkg::RCP_SH];
            s3_qw_next[c]  = NUM_W'(s2_q_reg[c]) * NUM_W'(stat.bw);
            // The estimate is short by at most one.
            s4_rem[c]      = s3_num_reg[c] - s3_qw_reg[c];
            if (!s3_blend_reg)
            begin
                out_pix_next[c] = s3_dst_reg[c];
            end
            else if (s4_rem[c] >= NUM_W'(stat.bw))
            begin
                out_pix_next[c] = s3_q_reg[c] + 1'b1;
            end
            else
            begin
                out_pix_next[c] = s3_q_reg[c];
            end
        end
        out_valid_next = advance ? s3_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                s1_valid_reg <= pop;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_blend_reg   <= pop_data.blend;
            s1_inside_reg  <= pop_data.in_span;
            s1_dst_reg     <= pop_data.dst;
            s1_num_reg     <= s1_num_next;
            s2_blend_reg   <= s1_blend_reg;
            s2_inside_reg  <= s1_inside_reg;
            s2_dst_reg     <= s1_dst_reg;
            s2_num_reg     <= s1_num_reg;
            s2_q_reg       <= s2_q_next;
            s3_blend_reg   <= s2_blend_reg;
            s3_inside_reg  <= s2_inside_reg;
            s3_dst_reg     <= s2_dst_reg;
            s3_num_reg     <= s2_num_reg;
            s3_q_reg       <= s2_q_reg;
            s3_qw_reg      <= s3_qw_next;
            out_pix_reg    <= out_pix_next;
            out_inside_reg <= s3_inside_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = out_pix_reg[0];
    assign out_green = out_pix_reg[1];
    assign out_blue  = out_pix_reg[2];
    assign in_blend  = out_inside_reg;

    // A single correction step must be enough for every channel.
    a_one_correction: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && s3_blend_reg) |->
        (({1'b0, s4_rem[0]} < ((NUM_W + 1)'(stat.bw) << 1)) &&
         ({1'b0, s4_rem[1]} < ((NUM_W + 1)'(stat.bw) << 1)) &&
         ({1'b0, s4_rem[2]} < ((NUM_W + 1)'(stat.bw) << 1))))
        else $error("quotient estimate off by more than one");

    // A blended word always lies inside the blend width.
    a_blend_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && s3_blend_reg) |-> s3_inside_reg)
        else $error("blend requested outside blend width");

endmodule

`default_nettype wire

// ===== rtl/seam_feather_blend.sv =====
// Top level of the seam feather blend: configuration, front, queue and back.
// A word passes the front register, the queue, the back stages and the output register.
// Throughput: one word per cycle without stalls, limited by the single-issue back pipeline.
// After reset and after every register write, in_stall stays high while the blend width is
// derived and, unless it is zero, a bit-serial divider forms 2^19 / width.
// Reset clears the registers to seam 0, width 4096, narrow interval, and empties all stages.
`default_nettype none

module seam_feather_blend (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // Configuration write channel.
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [sfb_pkg::WID_W-1:0] cfg_data,
    // Input pixel pairs.
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [sfb_pkg::COL_W-1:0] column,
    input  wire logic [sfb_pkg::PIX_W-1:0] src_red,
    input  wire logic [sfb_pkg::PIX_W-1:0] src_green,
    input  wire logic [sfb_pkg::PIX_W-1:0] src_blue,
    input  wire logic [sfb_pkg::PIX_W-1:0] dst_red,
    input  wire logic [sfb_pkg::PIX_W-1:0] dst_green,
    input  wire logic [sfb_pkg::PIX_W-1:0] dst_blue,
    // Output pixels.
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [sfb_pkg::PIX_W-1:0]      out_red,
    output logic [sfb_pkg::PIX_W-1:0]      out_green,
    output logic [sfb_pkg::PIX_W-1:0]      out_blue,
    output logic                           in_blend
);

    sfb_pkg::cfg_stat_t stat;
    sfb_pkg::item_t     push_data;
    sfb_pkg::item_t     pop_data;
    logic               push;
    logic               pop;
    logic               q_full;
    logic               q_empty;

    // Writes are always taken; seam, width and wide writes restart the blend width derivation.
    assign cfg_ready = 1'b1;

    // The configuration unit derives the blend width W and floor(2^K / W) so that
    // the back part can divide by W with a reciprocal multiply and one correction.
    sfb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stat      (stat)
    );

    // The front part decides per word whether it lies in the blend and whether the
    // source pixel is black; it holds one word while the queue is full.
    sfb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .column    (column),
        .src_red   (src_red),
        .src_green (src_green),
        .src_blue  (src_blue),
        .dst_red   (dst_red),
        .dst_green (dst_green),
        .dst_blue  (dst_blue),
        .stat      (stat),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    // The queue of four words lets the front keep taking words while the output stalls.
    sfb_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    // The back part forms s*(W-j)+d*j, estimates the quotient through the reciprocal,
    // corrects it by one where needed and registers the result.
    sfb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .stat      (stat),
        .q_empty   (q_empty),
        .pop       (pop),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .in_blend  (in_blend)
    );

endmodule

`default_nettype wire
